// File: src/lav_pkg.sv
// Shared constants, payload types and rounding helpers for the look-at matrix pipeline.
package lav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VW        = FRAC_BITS + 2;   // unit vector component, signed
  localparam int CW        = 32;              // coordinate and register width
  localparam int MAG_W     = VW + CW;         // magnitude bound of a normaliser input
  localparam int IN_W      = MAG_W + 1;       // signed normaliser input
  localparam int JW        = 64;              // left-justify word
  localparam int SH_STEPS  = 6;               // shifts of 32,16,8,4,2,1
  localparam int AW        = 30;              // scaled magnitude, top bit at 2^29
  localparam int SQW       = 2 * AW + 2;      // sum of squares
  localparam int SQ_STEPS  = AW + 1;          // root digits
  localparam int LW        = AW + 1;          // length width
  localparam int NUM_W     = AW + FRAC_BITS + 1;
  localparam int QB        = FRAC_BITS + 1;   // quotient digits
  localparam int DW        = VW + CW + 2;     // dot product width
  localparam int RW        = 18;              // rotation field width
  localparam int IDX_W     = 2;

  localparam logic [IDX_W-1:0] REG_UP_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_UP_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_UP_Z = 2'd2;

  localparam logic [CW-1:0] UP_X_RST = 32'd0;
  localparam logic [CW-1:0] UP_Y_RST = 32'd65536;
  localparam logic [CW-1:0] UP_Z_RST = 32'd0;

  // Data that rides along a normaliser untouched
  typedef struct packed {
    logic [2:0][CW-1:0] eye;
    logic [2:0][VW-1:0] f;
  } ctx_t;

  typedef struct packed {
    logic [2:0][JW-1:0] w;
    logic [JW-1:0]      m;
    logic [2:0]         neg;
    logic               zero;
    ctx_t               ctx;
  } sh_t;

  typedef struct packed {
    logic [2:0][AW-1:0] a;
    logic [2:0]         neg;
    logic               zero;
    ctx_t               ctx;
  } nrm_t;

  typedef struct packed {
    logic [SQW-1:0] n;
    logic [SQW-1:0] res;
    nrm_t           nd;
  } sq_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0] rem;
    logic [2:0][QB-1:0]    q;
    logic [LW-1:0]         len;
    logic [2:0]            neg;
    logic                  zero;
    ctx_t                  ctx;
  } dv_t;

  // Shift right by the fraction bits, rounding half away from zero
  function automatic logic signed [DW-1:0] rnd_shift(input logic signed [DW-1:0] v);
    logic [DW-1:0] mag;
    logic [DW-1:0] r;
    mag = v[DW-1] ? DW'(-v) : DW'(v);
    r   = (mag + (DW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[DW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [DW-1:0] clamp_one(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] one;
    one = $signed(DW'(1) << FRAC_BITS);
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic logic [CW-1:0] sat32(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] lo;
    hi = DW'($signed({1'b0, {(CW-1){1'b1}}}));
    lo = DW'($signed({1'b1, {(CW-1){1'b0}}}));
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

endpackage

// File: src/look_at_view_matrix_top.sv
// Top level of the fixed-point look-at view matrix pipeline.
// Takes one camera set-up (eye and aim point, Q16.16) per clock unless stalled and returns the
// twelve varying view-matrix entries at FRAC_BITS 16; the two normalisers are each a row of
// 31 square-root cells and 17 divider cells, so every cell holds one set-up in flight. The
// whole pipeline advances whenever the output register is empty or being taken, so a waiting
// result stalls intake only once it blocks the last stage. The world up vector is written
// via the register port only while the pipeline is empty; the user, not the block, ensures it.
module look_at_view_matrix_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lav_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]               cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // eye_x, eye_y, eye_z, aim_x, aim_y, aim_z (32 bits each)
  input  logic [191:0]              s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // side_x/y/z, true_up_x/y/z, back_x/y/z (18 bits each), shift_0/1/2 (32 bits each), pad
  output logic [263:0]              m_axis_tdata
);

  localparam int PX = lav_pkg::VW + lav_pkg::CW;
  localparam int PF = 2 * lav_pkg::VW;

  logic en;
  logic out_v_q;
  logic [263:0] out_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // World up registers
  logic [2:0][lav_pkg::CW-1:0] up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q[0] <= lav_pkg::UP_X_RST;
      up_q[1] <= lav_pkg::UP_Y_RST;
      up_q[2] <= lav_pkg::UP_Z_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lav_pkg::REG_UP_X: up_q[0] <= cfg_wdata_i;
        lav_pkg::REG_UP_Y: up_q[1] <= cfg_wdata_i;
        lav_pkg::REG_UP_Z: up_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Direction from eye to aim
  logic                          t0_v_q;
  logic [2:0][lav_pkg::IN_W-1:0] dir_q;
  lav_pkg::ctx_t                 ctx0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_v_q <= 1'b0;
    end else if (en) begin
      t0_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dir_q[i] <= lav_pkg::IN_W'($signed(s_axis_tdata[96 + 32*i +: 32]))
                  - lav_pkg::IN_W'($signed(s_axis_tdata[32*i +: 32]));
        ctx0_q.eye[i] <= s_axis_tdata[32*i +: 32];
      end
      ctx0_q.f <= '0;
    end
  end

  // Forward vector
  logic                        n1_v;
  logic [2:0][lav_pkg::VW-1:0] f_n1;
  lav_pkg::ctx_t               ctx_n1;

  lav_norm u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t0_v_q),
    .vec_i   (dir_q),
    .ctx_i   (ctx0_q),
    .valid_o (n1_v),
    .vec_o   (f_n1),
    .ctx_o   (ctx_n1)
  );

  // Cross product forward x up: products, then differences
  logic                  x1_v_q;
  logic signed [PX-1:0]  xp_q [6];
  lav_pkg::ctx_t         ctx_x1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_v_q <= 1'b0;
    end else if (en) begin
      x1_v_q <= n1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xp_q[0] <= PX'($signed(f_n1[1])) * PX'($signed(up_q[2]));
      xp_q[1] <= PX'($signed(f_n1[2])) * PX'($signed(up_q[1]));
      xp_q[2] <= PX'($signed(f_n1[2])) * PX'($signed(up_q[0]));
      xp_q[3] <= PX'($signed(f_n1[0])) * PX'($signed(up_q[2]));
      xp_q[4] <= PX'($signed(f_n1[0])) * PX'($signed(up_q[1]));
      xp_q[5] <= PX'($signed(f_n1[1])) * PX'($signed(up_q[0]));
      ctx_x1_q.eye <= ctx_n1.eye;
      ctx_x1_q.f   <= f_n1;
    end
  end

  logic                          x2_v_q;
  logic [2:0][lav_pkg::IN_W-1:0] crs_q;
  lav_pkg::ctx_t                 ctx_x2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x2_v_q <= 1'b0;
    end else if (en) begin
      x2_v_q <= x1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        crs_q[i] <= lav_pkg::IN_W'(xp_q[2*i]) - lav_pkg::IN_W'(xp_q[2*i+1]);
      end
      ctx_x2_q <= ctx_x1_q;
    end
  end

  // Side vector
  logic                        n2_v;
  logic [2:0][lav_pkg::VW-1:0] s_n2;
  lav_pkg::ctx_t               ctx_n2;

  lav_norm u_norm_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (x2_v_q),
    .vec_i   (crs_q),
    .ctx_i   (ctx_x2_q),
    .valid_o (n2_v),
    .vec_o   (s_n2),
    .ctx_o   (ctx_n2)
  );

  // Products for side x forward and the side and forward dots with eye
  logic                        p1_v_q;
  logic signed [PF-1:0]        sf_q [6];
  logic signed [PX-1:0]        se_q [3];
  logic signed [PX-1:0]        fe_q [3];
  logic [2:0][lav_pkg::VW-1:0] s1_q, f1_q;
  logic [2:0][lav_pkg::CW-1:0] eye1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= n2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sf_q[0] <= PF'($signed(s_n2[1])) * PF'($signed(ctx_n2.f[2]));
      sf_q[1] <= PF'($signed(s_n2[2])) * PF'($signed(ctx_n2.f[1]));
      sf_q[2] <= PF'($signed(s_n2[2])) * PF'($signed(ctx_n2.f[0]));
      sf_q[3] <= PF'($signed(s_n2[0])) * PF'($signed(ctx_n2.f[2]));
      sf_q[4] <= PF'($signed(s_n2[0])) * PF'($signed(ctx_n2.f[1]));
      sf_q[5] <= PF'($signed(s_n2[1])) * PF'($signed(ctx_n2.f[0]));
      for (int i = 0; i < 3; i++) begin
        se_q[i] <= PX'($signed(s_n2[i])) * PX'($signed(ctx_n2.eye[i]));
        fe_q[i] <= PX'($signed(ctx_n2.f[i])) * PX'($signed(ctx_n2.eye[i]));
      end
      s1_q   <= s_n2;
      f1_q   <= ctx_n2.f;
      eye1_q <= ctx_n2.eye;
    end
  end

  // Differences and dot sums
  logic                        p2_v_q;
  logic signed [lav_pkg::DW-1:0] ud_q [3];
  logic signed [lav_pkg::DW-1:0] t0_q, t2_q;
  logic [2:0][lav_pkg::VW-1:0] s2_q, f2_q;
  logic [2:0][lav_pkg::CW-1:0] eye2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (en) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ud_q[i] <= lav_pkg::DW'(sf_q[2*i]) - lav_pkg::DW'(sf_q[2*i+1]);
      end
      t0_q <= -(lav_pkg::DW'(se_q[0]) + lav_pkg::DW'(se_q[1]) + lav_pkg::DW'(se_q[2]));
      t2_q <= lav_pkg::DW'(fe_q[0]) + lav_pkg::DW'(fe_q[1]) + lav_pkg::DW'(fe_q[2]);
      s2_q   <= s1_q;
      f2_q   <= f1_q;
      eye2_q <= eye1_q;
    end
  end

  // Round the true up vector and the finished dots
  logic                          p3_v_q;
  logic [2:0][lav_pkg::VW-1:0]   u3_q, s3_q, f3_q;
  logic signed [lav_pkg::DW-1:0] t0r3_q, t2r3_q;
  logic [2:0][lav_pkg::CW-1:0]   eye3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else if (en) begin
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u3_q[i] <= lav_pkg::VW'(lav_pkg::clamp_one(lav_pkg::rnd_shift(ud_q[i])));
      end
      t0r3_q <= lav_pkg::rnd_shift(t0_q);
      t2r3_q <= lav_pkg::rnd_shift(t2_q);
      s3_q   <= s2_q;
      f3_q   <= f2_q;
      eye3_q <= eye2_q;
    end
  end

  // True up times eye
  logic                          p4_v_q;
  logic signed [PX-1:0]          ue_q [3];
  logic [2:0][lav_pkg::VW-1:0]   u4_q, s4_q, f4_q;
  logic signed [lav_pkg::DW-1:0] t0r4_q, t2r4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_v_q <= 1'b0;
    end else if (en) begin
      p4_v_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ue_q[i] <= PX'($signed(u3_q[i])) * PX'($signed(eye3_q[i]));
      end
      u4_q   <= u3_q;
      s4_q   <= s3_q;
      f4_q   <= f3_q;
      t0r4_q <= t0r3_q;
      t2r4_q <= t2r3_q;
    end
  end

  // Up dot sum
  logic                          p5_v_q;
  logic signed [lav_pkg::DW-1:0] t1_q;
  logic [2:0][lav_pkg::VW-1:0]   u5_q, s5_q, f5_q;
  logic signed [lav_pkg::DW-1:0] t0r5_q, t2r5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_v_q <= 1'b0;
    end else if (en) begin
      p5_v_q <= p4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q   <= -(lav_pkg::DW'(ue_q[0]) + lav_pkg::DW'(ue_q[1]) + lav_pkg::DW'(ue_q[2]));
      u5_q   <= u4_q;
      s5_q   <= s4_q;
      f5_q   <= f4_q;
      t0r5_q <= t0r4_q;
      t2r5_q <= t2r4_q;
    end
  end

  // Pack the result beat
  logic [263:0] out_d;

  always_comb begin
    out_d = '0;
    for (int i = 0; i < 3; i++) begin
      out_d[lav_pkg::RW*i +: lav_pkg::RW]       = lav_pkg::RW'($signed(s5_q[i]));
      out_d[lav_pkg::RW*(3+i) +: lav_pkg::RW]   = lav_pkg::RW'($signed(u5_q[i]));
      out_d[lav_pkg::RW*(6+i) +: lav_pkg::RW]   =
        lav_pkg::RW'(-$signed(lav_pkg::DW'($signed(f5_q[i]))));
    end
    out_d[162 +: 32] = lav_pkg::sat32(t0r5_q);
    out_d[194 +: 32] = lav_pkg::sat32(lav_pkg::rnd_shift(t1_q));
    out_d[226 +: 32] = lav_pkg::sat32(t2r5_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= p5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

// File: src/lav_shift_cell.sv
// Left-justify cell: shifts all three magnitudes while the largest keeps its top bits.
module lav_shift_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [2:0]    lg_i,     // shift by 2^lg_i
  input  logic          valid_i,
  input  lav_pkg::sh_t  data_i,
  output logic          valid_o,
  output lav_pkg::sh_t  data_o
);

  logic         valid_q;
  lav_pkg::sh_t data_d, data_q;
  logic [6:0]   sh;

  // Shift only when no set bit of the largest magnitude falls off the top
  always_comb begin
    data_d = data_i;
    sh     = 7'(1) << lg_i;
    if (((data_i.m << sh) >> sh) == data_i.m) begin
      data_d.m = data_i.m << sh;
      for (int i = 0; i < 3; i++) begin
        data_d.w[i] = data_i.w[i] << sh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/lav_sqrt_cell.sv
// Square-root cell: resolves one root digit of the sum of squares.
module lav_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [4:0]    idx_i,    // trial bit is 4^idx_i
  input  logic          valid_i,
  input  lav_pkg::sq_t  data_i,
  output logic          valid_o,
  output lav_pkg::sq_t  data_o
);

  logic                      valid_q;
  lav_pkg::sq_t              data_d, data_q;
  logic [lav_pkg::SQW-1:0]   bv;
  logic [lav_pkg::SQW-1:0]   trial;

  // Subtract the trial value where it fits and take the digit
  always_comb begin
    data_d = data_i;
    bv     = lav_pkg::SQW'(1) << {idx_i, 1'b0};
    trial  = data_i.res + bv;
    if (data_i.n >= trial) begin
      data_d.n   = data_i.n - trial;
      data_d.res = (data_i.res >> 1) + bv;
    end else begin
      data_d.res = data_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/lav_div_cell.sv
// Divider cell: one restoring quotient digit for each of the three lanes.
module lav_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [4:0]    idx_i,    // quotient digit weight 2^idx_i
  input  logic          valid_i,
  input  lav_pkg::dv_t  data_i,
  output logic          valid_o,
  output lav_pkg::dv_t  data_o
);

  logic                      valid_q;
  lav_pkg::dv_t              data_d, data_q;
  logic [lav_pkg::NUM_W-1:0] dsh;

  // Compare each remainder against the shifted length
  always_comb begin
    data_d = data_i;
    dsh    = lav_pkg::NUM_W'(data_i.len) << idx_i;
    for (int i = 0; i < 3; i++) begin
      if (data_i.rem[i] >= dsh) begin
        data_d.rem[i] = data_i.rem[i] - dsh;
        data_d.q[i]   = data_i.q[i] | (lav_pkg::QB'(1) << idx_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/lav_norm.sv
// Vector normaliser: scale, sum of squares, root and divide as rows of cells.
module lav_norm (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [2:0][lav_pkg::IN_W-1:0]        vec_i,
  input  lav_pkg::ctx_t                        ctx_i,
  output logic                                 valid_o,
  output logic [2:0][lav_pkg::VW-1:0]          vec_o,
  output lav_pkg::ctx_t                        ctx_o
);

  // Magnitudes, signs and the largest magnitude
  logic         a_v_q;
  lav_pkg::sh_t a_d, a_q;

  always_comb begin
    logic [lav_pkg::IN_W-1:0]  absv;
    logic [lav_pkg::MAG_W-1:0] mx;
    a_d     = '0;
    mx      = '0;
    a_d.ctx = ctx_i;
    for (int i = 0; i < 3; i++) begin
      a_d.neg[i] = vec_i[i][lav_pkg::IN_W-1];
      absv       = a_d.neg[i] ? lav_pkg::IN_W'(-$signed(vec_i[i])) : vec_i[i];
      a_d.w[i]   = lav_pkg::JW'(absv[lav_pkg::MAG_W-1:0]);
      if (absv[lav_pkg::MAG_W-1:0] > mx) begin
        mx = absv[lav_pkg::MAG_W-1:0];
      end
    end
    a_d.m    = lav_pkg::JW'(mx);
    a_d.zero = (mx == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
    end
  end

  // Left-justify row
  logic         sh_v [lav_pkg::SH_STEPS+1];
  lav_pkg::sh_t sh_d [lav_pkg::SH_STEPS+1];

  assign sh_v[0] = a_v_q;
  assign sh_d[0] = a_q;

  for (genvar k = 0; k < lav_pkg::SH_STEPS; k++) begin : g_sh
    lav_shift_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .lg_i    (3'(lav_pkg::SH_STEPS - 1 - k)),
      .valid_i (sh_v[k]),
      .data_i  (sh_d[k]),
      .valid_o (sh_v[k+1]),
      .data_o  (sh_d[k+1])
    );
  end

  // Squares of the scaled magnitudes
  logic                          q_v_q;
  logic [2:0][2*lav_pkg::AW-1:0] sq_q;
  lav_pkg::nrm_t                 nd_d, nd_q;

  always_comb begin
    nd_d.neg  = sh_d[lav_pkg::SH_STEPS].neg;
    nd_d.zero = sh_d[lav_pkg::SH_STEPS].zero;
    nd_d.ctx  = sh_d[lav_pkg::SH_STEPS].ctx;
    for (int i = 0; i < 3; i++) begin
      nd_d.a[i] = sh_d[lav_pkg::SH_STEPS].w[i][lav_pkg::JW-1 -: lav_pkg::AW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_v_q <= 1'b0;
    end else if (en_i) begin
      q_v_q <= sh_v[lav_pkg::SH_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nd_q <= nd_d;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (2*lav_pkg::AW)'(nd_d.a[i]) * (2*lav_pkg::AW)'(nd_d.a[i]);
      end
    end
  end

  // Sum of squares
  logic         s_v_q;
  lav_pkg::sq_t s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
    end else if (en_i) begin
      s_v_q <= q_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q.n   <= lav_pkg::SQW'(sq_q[0]) + lav_pkg::SQW'(sq_q[1]) + lav_pkg::SQW'(sq_q[2]);
      s_q.res <= '0;
      s_q.nd  <= nd_q;
    end
  end

  // Square-root row
  logic         r_v [lav_pkg::SQ_STEPS+1];
  lav_pkg::sq_t r_d [lav_pkg::SQ_STEPS+1];

  assign r_v[0] = s_v_q;
  assign r_d[0] = s_q;

  for (genvar k = 0; k < lav_pkg::SQ_STEPS; k++) begin : g_sq
    lav_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .idx_i   (5'(lav_pkg::SQ_STEPS - 1 - k)),
      .valid_i (r_v[k]),
      .data_i  (r_d[k]),
      .valid_o (r_v[k+1]),
      .data_o  (r_d[k+1])
    );
  end

  // Dividends with the half-length rounding term
  logic              p_v_q;
  lav_pkg::dv_t      p_d, p_q;
  lav_pkg::sq_t      r_last;
  logic [lav_pkg::LW-1:0] len;

  assign r_last = r_d[lav_pkg::SQ_STEPS];
  assign len    = r_last.res[lav_pkg::LW-1:0];

  always_comb begin
    p_d      = '0;
    p_d.len  = len;
    p_d.neg  = r_last.nd.neg;
    p_d.zero = r_last.nd.zero;
    p_d.ctx  = r_last.nd.ctx;
    for (int i = 0; i < 3; i++) begin
      p_d.rem[i] = (lav_pkg::NUM_W'(r_last.nd.a[i]) << lav_pkg::FRAC_BITS)
                 + lav_pkg::NUM_W'(len >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en_i) begin
      p_v_q <= r_v[lav_pkg::SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  // Divider row
  logic         d_v [lav_pkg::QB+1];
  lav_pkg::dv_t d_d [lav_pkg::QB+1];

  assign d_v[0] = p_v_q;
  assign d_d[0] = p_q;

  for (genvar k = 0; k < lav_pkg::QB; k++) begin : g_dv
    lav_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .idx_i   (5'(lav_pkg::QB - 1 - k)),
      .valid_i (d_v[k]),
      .data_i  (d_d[k]),
      .valid_o (d_v[k+1]),
      .data_o  (d_d[k+1])
    );
  end

  // Apply signs; a zero vector becomes the x axis
  logic                        o_v_q;
  logic [2:0][lav_pkg::VW-1:0] o_d, o_q;
  lav_pkg::ctx_t               c_q;
  lav_pkg::dv_t                d_last;

  assign d_last = d_d[lav_pkg::QB];

  always_comb begin
    logic [lav_pkg::VW-1:0] qv;
    for (int i = 0; i < 3; i++) begin
      qv     = lav_pkg::VW'(d_last.q[i]);
      o_d[i] = d_last.neg[i] ? lav_pkg::VW'(-$signed(qv)) : qv;
    end
    if (d_last.zero) begin
      o_d[0] = lav_pkg::VW'(1) << lav_pkg::FRAC_BITS;
      o_d[1] = '0;
      o_d[2] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (en_i) begin
      o_v_q <= d_v[lav_pkg::QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_q <= o_d;
      c_q <= d_last.ctx;
    end
  end

  assign valid_o = o_v_q;
  assign vec_o   = o_q;
  assign ctx_o   = c_q;

endmodule
